### src/rfrc_pkg.sv
`default_nettype none
package rfrc_pkg;

  // Frame geometry defaults
  localparam int unsigned HEADER_BYTES_DEF  = 6;
  localparam int unsigned DIRECTION_POS_DEF = 2;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam logic [BYTE_W-1:0] SUM_INIT  = 8'hFF;
  localparam logic [BYTE_W-1:0] LEN_NONE  = 8'hFF;

  // Register reset values
  localparam logic [BYTE_W-1:0] MARKER_RST      = 8'hF7;
  localparam logic [BYTE_W-1:0] STATUS_DIR_RST  = 8'h50;
  localparam logic [BYTE_W-1:0] CONTROL_DIR_RST = 8'h0F;
  localparam logic [BYTE_W-1:0] STATUS_SEED_RST = 8'h4B;
  localparam logic [BYTE_W-1:0] CONTROL_SEED_RST = 8'h62;
  localparam logic [BYTE_W-1:0] LENGTH_LIMIT_RST = 8'd64;

  // Register indexes on the configuration port
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MARKER       = 3'd0,
    CFG_STATUS_DIR   = 3'd1,
    CFG_CONTROL_DIR  = 3'd2,
    CFG_STATUS_SEED  = 3'd3,
    CFG_CONTROL_SEED = 3'd4,
    CFG_LENGTH_LIMIT = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_CHECK   = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    V_STATUS_OK   = 3'd0,
    V_CONTROL_OK  = 3'd1,
    V_SUM_BAD     = 3'd2,
    V_UNKNOWN_DIR = 3'd3,
    V_BAD_LEN     = 3'd4
  } verdict_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
  } rx_beat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic [BYTE_W-1:0] byte_index;
    logic              frame_first;
    logic              frame_last;
    verdict_t          verdict;
  } frame_beat_t;

  // Checksum unit control: restart from the initial value, absorb a byte, clear
  typedef struct packed {
    logic restart;
    logic absorb;
    logic clear;
  } sum_ctrl_t;

  // One checksum step: shift, fold the seed in on overflow, then mix the byte
  function automatic logic [BYTE_W-1:0] sum_step(input logic [BYTE_W-1:0] sum,
                                                 input logic [BYTE_W-1:0] seed,
                                                 input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] shifted;
    shifted = {sum[BYTE_W-2:0], 1'b0};
    if (sum[BYTE_W-1]) begin
      shifted = shifted ^ seed;
    end
    return shifted ^ b;
  endfunction

endpackage
`default_nettype wire

### src/rfrc_stream_if.sv
`default_nettype none
interface rfrc_stream_if #(
  parameter type payload_t = logic [7:0]
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### src/rs485_frame_receiver_checksum_top.sv
`default_nettype none
// Channel   Role    Beat payload
// rx        sink    rx_byte: one byte from the bus
// frame     source  frame_byte, byte_index, frame_first, frame_last, verdict
// cfg_*     write   cfg_we, cfg_index, cfg_data: one register per write
//
// One byte is taken every cycle while rx.ready is high; its result is registered.
// The output register is the only stage: rx.ready is low only while a result
// waits and frame.ready is low. Bytes that are dropped while hunting give no beat.
// rst is synchronous: registers return to their reset values, the frame state
// returns to hunting with both sums at 0xFF, and the output register empties.
module rs485_frame_receiver_checksum_top #(
  parameter int unsigned HEADER_BYTES  = rfrc_pkg::HEADER_BYTES_DEF,
  parameter int unsigned DIRECTION_POS = rfrc_pkg::DIRECTION_POS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  rfrc_stream_if.sink                           rx,
  rfrc_stream_if.source                         frame,
  input  wire logic                             cfg_we,
  input  wire logic [rfrc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [rfrc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rfrc_pkg::*;

  localparam logic [BYTE_W-1:0] LEN_POS = BYTE_W'(HEADER_BYTES - 1);
  localparam logic [BYTE_W-1:0] DIR_POS = BYTE_W'(DIRECTION_POS);

  // Configuration registers
  logic [BYTE_W-1:0] marker_byte;
  logic [BYTE_W-1:0] status_direction;
  logic [BYTE_W-1:0] control_direction;
  logic [BYTE_W-1:0] status_seed;
  logic [BYTE_W-1:0] control_seed;
  logic [BYTE_W-1:0] length_limit;

  // Frame state
  phase_t            phase;
  phase_t            phase_next;
  logic [BYTE_W-1:0] byte_count;
  logic [BYTE_W-1:0] byte_count_next;
  logic [BYTE_W-1:0] payload_length;
  logic [BYTE_W-1:0] payload_length_next;
  logic [BYTE_W-1:0] direction_seen;
  logic [BYTE_W-1:0] direction_seen_next;
  logic [BYTE_W-1:0] sum_status;
  logic [BYTE_W-1:0] sum_control;
  sum_ctrl_t         sum_ctrl;

  // Output register
  logic              out_valid;
  frame_beat_t       out_beat;
  frame_beat_t       beat_next;
  logic              emit;

  logic              accept;
  logic [BYTE_W-1:0] b;
  logic              is_marker;
  logic              len_bad;
  logic              header_end;

  assign rx.ready    = !out_valid || frame.ready;
  assign accept      = rx.valid && rx.ready;
  assign b           = rx.data.rx_byte;
  assign is_marker   = (b == marker_byte);
  assign len_bad     = (b == LEN_NONE) || (b >= length_limit);
  assign header_end  = (byte_count >= LEN_POS);
  assign frame.valid = out_valid;
  assign frame.data  = out_beat;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      marker_byte       <= MARKER_RST;
      status_direction  <= STATUS_DIR_RST;
      control_direction <= CONTROL_DIR_RST;
      status_seed       <= STATUS_SEED_RST;
      control_seed      <= CONTROL_SEED_RST;
      length_limit      <= LENGTH_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MARKER:       marker_byte       <= cfg_data;
        CFG_STATUS_DIR:   status_direction  <= cfg_data;
        CFG_CONTROL_DIR:  control_direction <= cfg_data;
        CFG_STATUS_SEED:  status_seed       <= cfg_data;
        CFG_CONTROL_SEED: control_seed      <= cfg_data;
        CFG_LENGTH_LIMIT: length_limit      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_HUNT: begin
        if (is_marker) phase_next = PH_HEADER;
      end
      PH_HEADER: begin
        if (header_end) begin
          if (len_bad) phase_next = PH_HUNT;
          else if (b == '0) phase_next = PH_CHECK;
          else phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (payload_length <= BYTE_W'(1)) phase_next = PH_CHECK;
      end
      PH_CHECK: phase_next = PH_HUNT;
      default: phase_next = PH_HUNT;
    endcase
  end

  // Counters, checksum control and the result beat
  always_comb begin
    byte_count_next      = byte_count;
    payload_length_next  = payload_length;
    direction_seen_next  = direction_seen;
    sum_ctrl             = '0;
    emit                 = 1'b1;
    beat_next.frame_byte  = b;
    beat_next.byte_index  = byte_count;
    beat_next.frame_first = 1'b0;
    beat_next.frame_last  = 1'b0;
    beat_next.verdict     = V_STATUS_OK;
    unique case (phase)
      PH_HUNT: begin
        emit = is_marker;
        if (is_marker) begin
          sum_ctrl.restart     = 1'b1;
          sum_ctrl.absorb      = 1'b1;
          byte_count_next      = BYTE_W'(1);
          payload_length_next  = '0;
          direction_seen_next  = '0;
          beat_next.byte_index  = '0;
          beat_next.frame_first = 1'b1;
        end
      end
      PH_HEADER: begin
        sum_ctrl.absorb = 1'b1;
        byte_count_next = byte_count + BYTE_W'(1);
        if (byte_count == DIR_POS) direction_seen_next = b;
        if (header_end) begin
          if (len_bad) begin
            // Abort: back to hunting with a fresh frame state
            sum_ctrl.absorb      = 1'b0;
            sum_ctrl.clear       = 1'b1;
            byte_count_next      = '0;
            payload_length_next  = '0;
            direction_seen_next  = '0;
            beat_next.frame_last = 1'b1;
            beat_next.verdict    = V_BAD_LEN;
          end else begin
            payload_length_next = b;
          end
        end
      end
      PH_PAYLOAD: begin
        sum_ctrl.absorb = 1'b1;
        byte_count_next = byte_count + BYTE_W'(1);
        if (payload_length <= BYTE_W'(1)) payload_length_next = '0;
        else payload_length_next = payload_length - BYTE_W'(1);
      end
      default: begin
        // Checksum byte: judge the frame and return to hunting
        sum_ctrl.clear       = 1'b1;
        byte_count_next      = '0;
        payload_length_next  = '0;
        direction_seen_next  = '0;
        beat_next.frame_last = 1'b1;
        if (direction_seen == status_direction)
          beat_next.verdict = (b == sum_status) ? V_STATUS_OK : V_SUM_BAD;
        else if (direction_seen == control_direction)
          beat_next.verdict = (b == sum_control) ? V_CONTROL_OK : V_SUM_BAD;
        else
          beat_next.verdict = V_UNKNOWN_DIR;
      end
    endcase
    if (!accept) sum_ctrl = '0;
  end

  rfrc_checksum u_checksum (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (sum_ctrl),
    .data         (b),
    .status_seed  (status_seed),
    .control_seed (control_seed),
    .sum_status   (sum_status),
    .sum_control  (sum_control)
  );

  // Advance the frame state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      byte_count     <= '0;
      payload_length <= '0;
      direction_seen <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      byte_count     <= byte_count_next;
      payload_length <= payload_length_next;
      direction_seen <= direction_seen_next;
    end
  end

  // Load the output register; drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= emit;
    end else if (frame.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) out_beat <= beat_next;
  end

  a_hunt_clean: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HUNT |-> byte_count == '0 && payload_length == '0 && direction_seen == '0
                         && sum_status == SUM_INIT && sum_control == SUM_INIT)
    else $error("hunting with leftover frame state");

  a_last_hunts: assert property (@(posedge clk) disable iff (rst)
    accept && emit && beat_next.frame_last |=> phase == PH_HUNT)
    else $error("frame ended but receiver did not return to hunting");

  a_first_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_beat.frame_first |->
      out_beat.byte_index == '0 && !out_beat.frame_last)
    else $error("opening beat has a bad index or closes the frame");

  a_bad_len_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_beat.frame_last && out_beat.verdict == V_BAD_LEN |->
      out_beat.byte_index == LEN_POS)
    else $error("length abort away from the length byte");

endmodule
`default_nettype wire

### src/rfrc_checksum.sv
`default_nettype none
module rfrc_checksum (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire rfrc_pkg::sum_ctrl_t         ctrl,
  input  wire logic [rfrc_pkg::BYTE_W-1:0] data,
  input  wire logic [rfrc_pkg::BYTE_W-1:0] status_seed,
  input  wire logic [rfrc_pkg::BYTE_W-1:0] control_seed,
  output logic      [rfrc_pkg::BYTE_W-1:0] sum_status,
  output logic      [rfrc_pkg::BYTE_W-1:0] sum_control
);
  import rfrc_pkg::*;

  logic [BYTE_W-1:0] base_status;
  logic [BYTE_W-1:0] base_control;

  // Start from the initial value when a new frame opens
  assign base_status  = ctrl.restart ? SUM_INIT : sum_status;
  assign base_control = ctrl.restart ? SUM_INIT : sum_control;

  // Advance both running sums, or return them to the initial value
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_status  <= SUM_INIT;
      sum_control <= SUM_INIT;
    end else if (ctrl.absorb) begin
      sum_status  <= sum_step(base_status, status_seed, data);
      sum_control <= sum_step(base_control, control_seed, data);
    end else if (ctrl.clear) begin
      sum_status  <= SUM_INIT;
      sum_control <= SUM_INIT;
    end
  end

  a_restart_absorbs: assert property (@(posedge clk) disable iff (rst)
    ctrl.restart && ctrl.absorb |=>
      sum_status == sum_step(SUM_INIT, $past(status_seed), $past(data)))
    else $error("checksum restart did not start from the initial value");

  a_clear_init: assert property (@(posedge clk) disable iff (rst)
    ctrl.clear && !ctrl.absorb |=> sum_status == SUM_INIT && sum_control == SUM_INIT)
    else $error("checksum clear left a stale sum");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !ctrl.clear && !ctrl.absorb |=> $stable(sum_status) && $stable(sum_control))
    else $error("checksum moved without a byte");

endmodule
`default_nettype wire
